// ===== rtl/kyber_base_multiply_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for kyber_base_multiply_top
// Clocked concurrent checks with and without reset gating; empty when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KYBER_BASE_MULTIPLY_TOP_ASSERT_SVH
`define KYBER_BASE_MULTIPLY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define KBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define KBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define KBM_ASSERT(label, prop, msg)
`define KBM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/kbm_pkg.sv =====
// ----------------------------------------------------------------------------
// kbm_pkg
// Constants and types shared by the base multiplier modules.
// ----------------------------------------------------------------------------
`default_nettype none
package kbm_pkg;

    localparam int KBM_W      = 16;
    localparam int KBM_STAGES = 7;
    localparam int KBM_IDX_W  = 2;

    // modulus and q^-1 mod 2^16
    localparam logic signed [KBM_W-1:0] KBM_Q            = 16'sd3329;
    localparam logic        [KBM_W-1:0] KBM_QINV         = 16'hF301;  // -3327
    localparam logic signed [KBM_W-1:0] KBM_TWIDDLE_RST  = -16'sd1103;

    localparam logic [KBM_IDX_W-1:0] KBM_REG_KEY_LOW  = 2'd0;
    localparam logic [KBM_IDX_W-1:0] KBM_REG_KEY_HIGH = 2'd1;
    localparam logic [KBM_IDX_W-1:0] KBM_REG_TWIDDLE  = 2'd2;

    // load enables of one Montgomery lane: product, quotient, result
    typedef struct packed {
        logic prod;
        logic red;
        logic fin;
    } t_kbm_mont_en;

    typedef struct packed {
        t_kbm_mont_en mont;
        logic         outp;
    } t_kbm_merge_en;

endpackage
`default_nettype wire

// ===== rtl/kbm_mont.sv =====
// ----------------------------------------------------------------------------
// kbm_mont
// One lane: signed 16x16 multiply followed by Montgomery reduction, 3 stages.
// ----------------------------------------------------------------------------
`default_nettype none
module kbm_mont (
    input  wire logic                                i_clk,
    input  wire kbm_pkg::t_kbm_mont_en               i_en,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_a,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_b,
    output logic signed [kbm_pkg::KBM_W-1:0]         o_r
);

    logic signed [2*kbm_pkg::KBM_W-1:0] r_prod;
    logic signed [2*kbm_pkg::KBM_W-1:0] r_x;
    logic signed [kbm_pkg::KBM_W-1:0]   r_t;
    logic signed [kbm_pkg::KBM_W-1:0]   r_r;

    logic        [kbm_pkg::KBM_W-1:0]   w_t;
    logic signed [2*kbm_pkg::KBM_W-1:0] w_tq;
    logic        [2*kbm_pkg::KBM_W-1:0] w_diff;

    // t = low16(x) * qinv mod 2^16
    assign w_t    = r_prod[kbm_pkg::KBM_W-1:0] * kbm_pkg::KBM_QINV;
    assign w_tq   = (2*kbm_pkg::KBM_W)'(r_t) * (2*kbm_pkg::KBM_W)'(kbm_pkg::KBM_Q);
    // low half of the difference is zero; upper half is the reduced value
    assign w_diff = r_x - w_tq;

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_prod <= (2*kbm_pkg::KBM_W)'(i_a) * (2*kbm_pkg::KBM_W)'(i_b);
        end
        if (i_en.red) begin
            r_x <= r_prod;
            r_t <= w_t;
        end
        if (i_en.fin) begin
            r_r <= w_diff[2*kbm_pkg::KBM_W-1:kbm_pkg::KBM_W];
        end
    end

    assign o_r = r_r;

endmodule
`default_nettype wire

// ===== rtl/kbm_merge.sv =====
// ----------------------------------------------------------------------------
// kbm_merge
// Combines the lane results: twiddle reduction of the high-high term,
// aligned wrapping sums, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module kbm_merge (
    input  wire logic                                i_clk,
    input  wire kbm_pkg::t_kbm_merge_en              i_en,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_hh,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_ll,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_lh,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_hl,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]    i_twiddle,
    output logic signed [kbm_pkg::KBM_W-1:0]         o_prod_low,
    output logic signed [kbm_pkg::KBM_W-1:0]         o_prod_high
);

    logic signed [kbm_pkg::KBM_W-1:0] w_hh_tw;
    logic signed [kbm_pkg::KBM_W-1:0] r_ll_d1, r_ll_d2, r_ll_d3;
    logic signed [kbm_pkg::KBM_W-1:0] r_cross_d1, r_cross_d2, r_cross_d3;
    logic signed [kbm_pkg::KBM_W-1:0] r_prod_low, r_prod_high;

    kbm_mont u_tw (
        .i_clk (i_clk),
        .i_en  (i_en.mont),
        .i_a   (i_hh),
        .i_b   (i_twiddle),
        .o_r   (w_hh_tw)
    );

    // delay line matches the twiddle lane; cross terms summed early
    always_ff @(posedge i_clk) begin
        if (i_en.mont.prod) begin
            r_ll_d1    <= i_ll;
            r_cross_d1 <= i_lh + i_hl;
        end
        if (i_en.mont.red) begin
            r_ll_d2    <= r_ll_d1;
            r_cross_d2 <= r_cross_d1;
        end
        if (i_en.mont.fin) begin
            r_ll_d3    <= r_ll_d2;
            r_cross_d3 <= r_cross_d2;
        end
        if (i_en.outp) begin
            r_prod_low  <= w_hh_tw + r_ll_d3;
            r_prod_high <= r_cross_d3;
        end
    end

    assign o_prod_low  = r_prod_low;
    assign o_prod_high = r_prod_high;

endmodule
`default_nettype wire

// ===== rtl/kyber_base_multiply_top.sv =====
// ----------------------------------------------------------------------------
// kyber_base_multiply_top
// Base multiplication of degree-one polynomials mod X^2 - zeta, q = 3329,
// with Montgomery reduction, four parallel lanes and a merge stage.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_coeff_low_in, i_coeff_high_in
//  out       output     o_out_valid / i_out_ready o_prod_low, o_prod_high
//  cfg       input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
//  One transaction per cycle sustained while i_out_ready holds; seven register
//  stages: three in the product lanes, three in the twiddle lane, one output
//  register.
//  Reset (synchronous, active low) empties the pipeline and loads the key
//  coefficients with zero and the twiddle with -1103.
//  Each stage stalls only when it and every stage after it hold data, so
//  bubbles are squeezed out and input is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kyber_base_multiply_top_assert.svh"
module kyber_base_multiply_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [kbm_pkg::KBM_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [kbm_pkg::KBM_W-1:0]             i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]      i_coeff_low_in,
    input  wire logic signed [kbm_pkg::KBM_W-1:0]      i_coeff_high_in,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [kbm_pkg::KBM_W-1:0]           o_prod_low,
    output logic signed [kbm_pkg::KBM_W-1:0]           o_prod_high
);

    // configuration registers
    logic signed [kbm_pkg::KBM_W-1:0] r_key_low, r_key_high, r_twiddle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_twiddle  <= kbm_pkg::KBM_TWIDDLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kbm_pkg::KBM_REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                kbm_pkg::KBM_REG_KEY_HIGH: r_key_high <= i_cfg_data;
                kbm_pkg::KBM_REG_TWIDDLE:  r_twiddle  <= i_cfg_data;
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // pipeline occupancy; stage 6 is the output register
    logic [kbm_pkg::KBM_STAGES-1:0] r_v, n_v;
    logic [kbm_pkg::KBM_STAGES-1:0] w_en;

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        w_en[kbm_pkg::KBM_STAGES-1] = !r_v[kbm_pkg::KBM_STAGES-1] || i_out_ready;
        for (int k = kbm_pkg::KBM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_en[0]) begin
            n_v[0] = i_in_valid;
        end
        for (int k = 1; k < kbm_pkg::KBM_STAGES; k++) begin
            if (w_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[kbm_pkg::KBM_STAGES-1];

    // lane enables
    kbm_pkg::t_kbm_mont_en  w_lane_en;
    kbm_pkg::t_kbm_merge_en w_merge_en;

    assign w_lane_en.prod       = w_en[0];
    assign w_lane_en.red        = w_en[1];
    assign w_lane_en.fin        = w_en[2];
    assign w_merge_en.mont.prod = w_en[3];
    assign w_merge_en.mont.red  = w_en[4];
    assign w_merge_en.mont.fin  = w_en[5];
    assign w_merge_en.outp      = w_en[6];

    // four product lanes: a1*b1, a0*b0, a0*b1, a1*b0
    logic signed [kbm_pkg::KBM_W-1:0] w_hh, w_ll, w_lh, w_hl;

    kbm_mont u_lane_hh (
        .i_clk (i_clk), .i_en (w_lane_en),
        .i_a (r_key_high), .i_b (i_coeff_high_in), .o_r (w_hh)
    );

    kbm_mont u_lane_ll (
        .i_clk (i_clk), .i_en (w_lane_en),
        .i_a (r_key_low), .i_b (i_coeff_low_in), .o_r (w_ll)
    );

    kbm_mont u_lane_lh (
        .i_clk (i_clk), .i_en (w_lane_en),
        .i_a (r_key_low), .i_b (i_coeff_high_in), .o_r (w_lh)
    );

    kbm_mont u_lane_hl (
        .i_clk (i_clk), .i_en (w_lane_en),
        .i_a (r_key_high), .i_b (i_coeff_low_in), .o_r (w_hl)
    );

    // twiddle reduction of the high-high term and final sums
    kbm_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (w_merge_en),
        .i_hh        (w_hh),
        .i_ll        (w_ll),
        .i_lh        (w_lh),
        .i_hl        (w_hl),
        .i_twiddle   (r_twiddle),
        .o_prod_low  (o_prod_low),
        .o_prod_high (o_prod_high)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic w_in_acc, w_out_acc;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // occupancy tracks accepted minus delivered transactions
    property p_occupancy;
        $past(i_rst_n) |-> ($countones(r_v) == $past($countones(r_v))
                            + $past(32'(w_in_acc)) - $past(32'(w_out_acc)));
    endproperty

    `KBM_ASSERT(a_occupancy, p_occupancy, "pipeline occupancy lost or gained a transaction")
    // input backpressure only when every stage is full
    `KBM_ASSERT(a_ready_full, !o_in_ready |-> (&r_v), "input stalled with an empty stage")
    // nothing leaves right after reset
    `KBM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
`default_nettype wire
